### rtl/sfbf_pkg.sv
// ----------------------------------------------------------------------------
// sfbf_pkg
// Shared types, constants and the SECDED(13,8) encoder for the bit framer.
// ----------------------------------------------------------------------------
package sfbf_pkg;

    localparam int PREAMBLE_BITS_DEF = 32;
    localparam int CW_BITS           = 13;
    localparam int SYNC_BITS         = 8;
    localparam int FREQ_W            = 15;
    localparam int CFG_IDX_W         = 2;

    localparam logic [FREQ_W-1:0]    FREQ_ZERO_RST = 15'd6000;
    localparam logic [FREQ_W-1:0]    FREQ_ONE_RST  = 15'd8000;
    localparam logic [SYNC_BITS-1:0] SYNC_RST      = 8'hD5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 2'd2;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic              bit_value;
        logic [FREQ_W-1:0] tone_hz;
        logic              in_preamble;
        logic              last;
    } out_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic               is_start;
        logic [CW_BITS-1:0] codeword;
    } cmd_t;

    typedef struct packed {
        logic [FREQ_W-1:0]    freq_zero_hz;
        logic [FREQ_W-1:0]    freq_one_hz;
        logic [SYNC_BITS-1:0] sync_word;
    } cfg_t;

    // Hamming(12,8) with parity at positions 1,2,4,8 plus overall parity
    function automatic logic [CW_BITS-1:0] secded13(input logic [7:0] b);
        logic d1, d2, d3, d4, d5, d6, d7, d8;
        logic p1, p2, p4, p8;
        logic [11:0] w;
        d1 = b[7]; d2 = b[6]; d3 = b[5]; d4 = b[4];
        d5 = b[3]; d6 = b[2]; d7 = b[1]; d8 = b[0];
        p1 = d1 ^ d2 ^ d4 ^ d5 ^ d7;
        p2 = d1 ^ d3 ^ d4 ^ d6 ^ d7;
        p4 = d2 ^ d3 ^ d4 ^ d8;
        p8 = d5 ^ d6 ^ d7 ^ d8;
        w  = {d8, d7, d6, d5, p8, d4, d3, d2, p4, d1, p2, p1};
        return {^w, w};
    endfunction

endpackage

### rtl/sfbf_front.sv
// ----------------------------------------------------------------------------
// sfbf_front
// Accepts input items, classifies them and encodes data bytes for the queue.
// ----------------------------------------------------------------------------
module sfbf_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  sfbf_pkg::in_t   s_data,
    input  logic            q_full,
    output logic            q_push,
    output sfbf_pkg::cmd_t  q_cmd
);

    // Take an item whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify and encode
    always_comb begin
        q_cmd.is_start = (s_data.kind == sfbf_pkg::KIND_START);
        if (s_data.kind == sfbf_pkg::KIND_DATA) begin
            q_cmd.codeword = sfbf_pkg::secded13(s_data.data_byte);
        end else begin
            q_cmd.codeword = '0;
        end
    end

endmodule

### rtl/sfbf_queue.sv
// ----------------------------------------------------------------------------
// sfbf_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sfbf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sfbf_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output sfbf_pkg::cmd_t  head_cmd
);

    sfbf_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/sfbf_back.sv
// ----------------------------------------------------------------------------
// sfbf_back
// Serializes preamble runs and codewords, one bit per transfer.
// ----------------------------------------------------------------------------
module sfbf_back #(
    parameter int PreambleBits = sfbf_pkg::PREAMBLE_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  sfbf_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  sfbf_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output sfbf_pkg::out_t  m_data
);

    localparam int PosW = $clog2(PreambleBits + sfbf_pkg::SYNC_BITS);
    localparam logic [PosW-1:0] PreLen    = PosW'(PreambleBits);
    localparam logic [PosW-1:0] StartLast = PosW'(PreambleBits + sfbf_pkg::SYNC_BITS - 1);
    localparam logic [PosW-1:0] DataLast  = PosW'(sfbf_pkg::CW_BITS - 1);
    localparam logic [2:0]      SyncTop   = 3'(sfbf_pkg::SYNC_BITS - 1);
    localparam logic [3:0]      CwTop     = 4'(sfbf_pkg::CW_BITS - 1);

    logic            busy_reg, busy_next;
    sfbf_pkg::cmd_t  cmd_reg, cmd_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic            m_valid_reg, m_valid_next;
    sfbf_pkg::out_t  m_data_reg, m_data_next;

    sfbf_pkg::cmd_t  sel_cmd;
    logic [PosW-1:0] sel_pos;
    logic [2:0]      sync_ofs;
    logic            have, advance, bit_val, bit_last;

    assign advance = !m_valid_reg || m_ready;
    assign have    = busy_reg || q_valid;
    assign sel_cmd = busy_reg ? cmd_reg : q_cmd;
    assign sel_pos = busy_reg ? pos_reg : '0;
    assign q_pop   = advance && !busy_reg && q_valid;
    assign sync_ofs = 3'(sel_pos - PreLen);

    // Pick the bit at the current run position
    always_comb begin
        if (sel_cmd.is_start) begin
            if (sel_pos < PreLen) begin
                bit_val = sel_pos[0];
            end else begin
                bit_val = cfg.sync_word[SyncTop - sync_ofs];
            end
            bit_last = (sel_pos == StartLast);
        end else begin
            bit_val  = sel_cmd.codeword[CwTop - sel_pos[3:0]];
            bit_last = (sel_pos == DataLast);
        end
    end

    // Advance the run and load the output register
    always_comb begin
        busy_next    = busy_reg;
        cmd_next     = cmd_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = have;
            if (have) begin
                m_data_next.bit_value   = bit_val;
                m_data_next.tone_hz     = bit_val ? cfg.freq_one_hz : cfg.freq_zero_hz;
                m_data_next.in_preamble = sel_cmd.is_start;
                m_data_next.last        = bit_last;
                busy_next               = !bit_last;
                cmd_next                = sel_cmd;
                pos_next                = sel_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/secded_fsk_bit_framer_top.sv
// ----------------------------------------------------------------------------
// secded_fsk_bit_framer_top
// SECDED(13,8) encoder and FSK bit framer with preamble and sync word.
// ----------------------------------------------------------------------------
// A start item (kind 0) produces PreambleBits alternating bits beginning with
// 0 followed by the 8-bit sync word MSB first; a data item (kind 1) produces
// its 13-bit SECDED codeword MSB first. Each result carries one bit, its tone,
// a preamble flag and a last-of-run mark. The serializer emits one bit per
// cycle while m_ready takes it; a data item gives 13 bits and a start item
// PreambleBits + 8; consecutive runs follow with no gap. A two-entry command
// queue lets up to two items be accepted ahead of the run being serialized.
// ----------------------------------------------------------------------------
module secded_fsk_bit_framer_top #(
    parameter int PreambleBits = sfbf_pkg::PREAMBLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [sfbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfbf_pkg::FREQ_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sfbf_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sfbf_pkg::out_t                     m_data
);

    sfbf_pkg::cfg_t cfg_reg;
    sfbf_pkg::cmd_t push_cmd, head_cmd;
    logic           q_push, q_full, q_pop, q_valid;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.freq_zero_hz <= sfbf_pkg::FREQ_ZERO_RST;
            cfg_reg.freq_one_hz  <= sfbf_pkg::FREQ_ONE_RST;
            cfg_reg.sync_word    <= sfbf_pkg::SYNC_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sfbf_pkg::REG_FREQ_ZERO: cfg_reg.freq_zero_hz <= cfg_wdata;
                sfbf_pkg::REG_FREQ_ONE:  cfg_reg.freq_one_hz  <= cfg_wdata;
                sfbf_pkg::REG_SYNC_WORD: cfg_reg.sync_word    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    sfbf_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    sfbf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    sfbf_back #(
        .PreambleBits (PreambleBits)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    // Come out of reset empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("framer not empty after reset");

    // Pop only a queued command
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // A queued command that is not popped stays queued
    a_queue_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_pop |=> q_valid)
        else $error("queued command lost");
`endif

endmodule
